@@ hw/rtl/fsnm_pkg.sv @@
// Shared types and constants for the FAT short-name entry matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package fsnm_pkg;

  localparam int unsigned NAME_MAX = 12;

  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] ATTR_LFN     = 8'h0F;
  localparam logic [7:0] ATTR_VOLUME  = 8'h08;
  localparam logic [7:0] ATTR_DIR     = 8'h10;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;
  localparam logic [7:0] NUL_CHAR     = 8'h00;

  localparam int unsigned ATTR_OFF    = 11;
  localparam int unsigned CL_HIGH_OFF = 'h14;
  localparam int unsigned CL_LOW_OFF  = 'h1A;
  localparam int unsigned SIZE_OFF    = 'h1C;

  localparam logic [3:0] NAME_LEN_MAX = 4'd12;

  typedef enum logic [1:0] {
    STAT_NO_MATCH = 2'd0,
    STAT_MATCH    = 2'd1,
    STAT_END      = 2'd2
  } entry_status_t;

  typedef enum logic [1:0] {
    CFG_TARGET_LOW    = 2'd0,
    CFG_TARGET_HIGH   = 2'd1,
    CFG_TARGET_LENGTH = 2'd2
  } cfg_index_t;

  typedef logic [31:0][7:0] entry_t;
  typedef logic [NAME_MAX-1:0][7:0] name_chars_t;

  typedef struct packed {
    logic        end_mark;
    logic        eligible;
    name_chars_t chars;
    logic [3:0]  len;
  } entry_info_t;

endpackage

`default_nettype wire

@@ hw/rtl/fsnm_entry_decode.sv @@
// Classifies a directory entry and builds its 8.3 short name, cut at the first NUL.
// Depends on fsnm_pkg.
`default_nettype none

module fsnm_entry_decode (
  input  var fsnm_pkg::entry_t      entry,
  output var fsnm_pkg::entry_info_t info
);
  import fsnm_pkg::*;

  logic [7:0] attr;
  logic [3:0] base_len;
  logic       base_done;
  logic       has_ext;
  logic       ns9;
  logic       ns10;
  logic [3:0] full_len;
  logic [3:0] cut_len;
  logic       cut_done;
  logic [3:0] q;
  name_chars_t chars;

  assign attr = entry[ATTR_OFF];

  always_comb begin
    base_len  = 4'd0;
    base_done = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!base_done && entry[i] != SPACE_CHAR) begin
        base_len = base_len + 4'd1;
      end else begin
        base_done = 1'b1;
      end
    end
  end

  assign has_ext  = entry[8] != SPACE_CHAR;
  assign ns9      = entry[9] != SPACE_CHAR;
  assign ns10     = entry[10] != SPACE_CHAR;
  assign full_len = has_ext ? (base_len + 4'd2 + {3'd0, ns9} + {3'd0, ns10}) : base_len;

  always_comb begin
    chars = '0;
    q     = 4'd0;
    for (int p = 0; p < NAME_MAX; p++) begin
      q = 4'(p) - base_len;
      if (4'(p) < base_len) begin
        chars[p] = entry[p];
      end else begin
        case (q)
          4'd0:    chars[p] = DOT_CHAR;
          4'd1:    chars[p] = entry[8];
          4'd2:    chars[p] = ns9 ? entry[9] : entry[10];
          4'd3:    chars[p] = entry[10];
          default: chars[p] = NUL_CHAR;
        endcase
      end
    end
  end

  always_comb begin
    cut_len  = full_len;
    cut_done = 1'b0;
    for (int p = 0; p < NAME_MAX; p++) begin
      if (!cut_done && 4'(p) < full_len && chars[p] == NUL_CHAR) begin
        cut_len  = 4'(p);
        cut_done = 1'b1;
      end
    end
  end

  assign info.end_mark = entry[0] == NUL_CHAR;
  assign info.eligible = entry[0] != DELETED_MARK
                      && (attr & ATTR_LFN) != ATTR_LFN
                      && (attr & ATTR_VOLUME) == 8'h00
                      && (attr & ATTR_DIR) == 8'h00;
  assign info.chars    = chars;
  assign info.len      = cut_len;

endmodule

`default_nettype wire

@@ hw/rtl/fsnm_target_match.sv @@
// Compares a built short name with the target name and forms the result fields.
// Depends on fsnm_pkg.
`default_nettype none

module fsnm_target_match (
  input  var fsnm_pkg::entry_info_t   info,
  input  var fsnm_pkg::entry_t        entry,
  input  var logic [63:0]             target_chars_low,
  input  var logic [31:0]             target_chars_high,
  input  var logic [3:0]              target_length,
  output var fsnm_pkg::entry_status_t entry_status,
  output var logic [31:0]             first_cluster,
  output var logic [31:0]             file_size
);
  import fsnm_pkg::*;

  name_chars_t tgt;
  logic [3:0]  tgt_len;
  logic        tgt_done;
  logic        chars_eq;
  logic        hit;

  assign tgt = {target_chars_high, target_chars_low};

  always_comb begin
    tgt_len  = 4'd0;
    tgt_done = 1'b0;
    for (int i = 0; i < NAME_MAX; i++) begin
      if (!tgt_done && 4'(i) < target_length) begin
        if (tgt[i] == NUL_CHAR) begin
          tgt_done = 1'b1;
        end else begin
          tgt_len = tgt_len + 4'd1;
        end
      end
    end
  end

  always_comb begin
    chars_eq = 1'b1;
    for (int i = 0; i < NAME_MAX; i++) begin
      if (4'(i) < info.len && tgt[i] != info.chars[i]) begin
        chars_eq = 1'b0;
      end
    end
  end

  assign hit = !info.end_mark && info.eligible && target_length <= NAME_LEN_MAX
            && tgt_len == info.len && chars_eq;

  always_comb begin
    if (info.end_mark) begin
      entry_status = STAT_END;
    end else if (hit) begin
      entry_status = STAT_MATCH;
    end else begin
      entry_status = STAT_NO_MATCH;
    end
  end

  assign first_cluster = hit ? {entry[CL_HIGH_OFF+1], entry[CL_HIGH_OFF],
                                entry[CL_LOW_OFF+1], entry[CL_LOW_OFF]} : 32'd0;
  assign file_size     = hit ? {entry[SIZE_OFF+3], entry[SIZE_OFF+2],
                                entry[SIZE_OFF+1], entry[SIZE_OFF]} : 32'd0;

endmodule

`default_nettype wire

@@ hw/rtl/fat_short_name_entry_matcher_core.sv @@
// Top level of the FAT short-name entry matcher: config registers, input and result stages.
// Depends on fsnm_pkg, fsnm_entry_decode and fsnm_target_match.
//
//   channel | dir | sideband            | payload
//   in_     | in  | -                   | 256-bit directory entry
//   out_    | out | tuser: entry_status | first_cluster, file_size
//   cfg_    | in  | -                   | register index and data
//
// One beat per cycle unless out_tready stalls; beats pass ent_r, then out_data_r.
// The entry register and the result register hold only one item each, so a stalled
// result backs up through the entry stage to in_tready within the same cycle.
// Reset clears both valid flags and the target registers.
`default_nettype none

module fat_short_name_entry_matcher_core (
  input  var logic         clk,
  input  var logic         rst_n,
  input  var logic         in_tvalid,
  output var logic         in_tready,
  // entry_bytes_0_7, entry_bytes_8_15, entry_bytes_16_23, entry_bytes_24_31
  input  var logic [255:0] in_tdata,
  output var logic         out_tvalid,
  input  var logic         out_tready,
  // first_cluster, file_size
  output var logic [63:0]  out_tdata,
  // entry_status
  output var logic [1:0]   out_tuser,
  input  var logic         cfg_we,
  input  var logic [1:0]   cfg_index,
  input  var logic [63:0]  cfg_data
);
  import fsnm_pkg::*;

  logic [63:0]   tgt_low_r;
  logic [31:0]   tgt_high_r;
  logic [3:0]    tgt_len_r;
  logic          ent_vld_r;
  entry_t        ent_r;
  logic          out_vld_r;
  logic [63:0]   out_data_r;
  logic [1:0]    out_user_r;
  logic          out_adv;
  logic          ent_adv;
  entry_info_t   info;
  entry_status_t status_nxt;
  logic [31:0]   cluster_nxt;
  logic [31:0]   size_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_low_r  <= '0;
      tgt_high_r <= '0;
      tgt_len_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_LOW:    tgt_low_r  <= cfg_data;
        CFG_TARGET_HIGH:   tgt_high_r <= cfg_data[31:0];
        CFG_TARGET_LENGTH: tgt_len_r  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign out_adv   = !out_vld_r || out_tready;
  assign ent_adv   = ent_vld_r && out_adv;
  assign in_tready = !ent_vld_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= 1'b0;
    end else if (in_tready) begin
      ent_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ent_r <= in_tdata;
    end
  end

  fsnm_entry_decode u_decode (
    .entry (ent_r),
    .info  (info)
  );

  fsnm_target_match u_match (
    .info              (info),
    .entry             (ent_r),
    .target_chars_low  (tgt_low_r),
    .target_chars_high (tgt_high_r),
    .target_length     (tgt_len_r),
    .entry_status      (status_nxt),
    .first_cluster     (cluster_nxt),
    .file_size         (size_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= ent_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ent_adv) begin
      out_data_r <= {size_nxt, cluster_nxt};
      out_user_r <= status_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

`default_nettype wire

@@ tb/fsnm_match_checker.sv @@
// Checker for the FAT short-name entry matcher: watches the entry, result and config ports,
// classifies each accepted entry itself and compares every result beat field by field.
// Depends on fsnm_pkg only.
module fsnm_match_checker (
  input  var logic         clk,
  input  var logic         rst_n,
  input  var logic         in_tvalid,
  input  var logic         in_tready,
  input  var logic [255:0] in_tdata,
  input  var logic         out_tvalid,
  input  var logic         out_tready,
  input  var logic [63:0]  out_tdata,
  input  var logic [1:0]   out_tuser,
  input  var logic         cfg_we,
  input  var logic [1:0]   cfg_index,
  input  var logic [63:0]  cfg_data,
  output int               fail_count,
  output int               pending_results,
  output int               match_count,
  output int               end_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import fsnm_pkg::*;

  typedef struct packed {
    entry_status_t status;
    logic [31:0]   first_cluster;
    logic [31:0]   file_size;
  } entry_verdict_t;

  logic [63:0] tgt_low;
  logic [31:0] tgt_high;
  logic [3:0]  tgt_len;

  entry_verdict_t awaited_verdicts[$];

  function automatic entry_verdict_t classify_entry(input entry_t e);
    entry_verdict_t v;
    logic [7:0] attr;
    logic [7:0] c;
    logic [7:0] built[NAME_MAX];
    logic [7:0] tgt[NAME_MAX];
    int n;
    int tn;
    bit same;
    v.status = STAT_NO_MATCH;
    v.first_cluster = '0;
    v.file_size = '0;
    n = 0;
    tn = 0;
    if (e[0] == NUL_CHAR) begin
      v.status = STAT_END;
      return v;
    end
    attr = e[ATTR_OFF];
    if (e[0] == DELETED_MARK || (attr & ATTR_LFN) == ATTR_LFN ||
        (attr & ATTR_VOLUME) != 0 || (attr & ATTR_DIR) != 0)
      return v;
    if (tgt_len > NAME_LEN_MAX)
      return v;
    for (int i = 0; i < 8 && e[i] != SPACE_CHAR; i++) begin
      built[n] = e[i];
      n++;
    end
    if (e[8] != SPACE_CHAR) begin
      built[n] = DOT_CHAR;
      built[n+1] = e[8];
      n += 2;
      if (e[9] != SPACE_CHAR) begin
        built[n] = e[9];
        n++;
      end
      if (e[10] != SPACE_CHAR) begin
        built[n] = e[10];
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (built[i] == NUL_CHAR) begin
        n = i;
        break;
      end
    end
    for (int i = 0; i < int'(tgt_len); i++) begin
      c = (i < 8) ? tgt_low[i*8 +: 8] : tgt_high[(i-8)*8 +: 8];
      if (c == NUL_CHAR)
        break;
      tgt[tn] = c;
      tn++;
    end
    same = (tn == n);
    for (int i = 0; same && i < n; i++)
      if (tgt[i] != built[i])
        same = 1'b0;
    if (same) begin
      v.status = STAT_MATCH;
      v.first_cluster = {e[CL_HIGH_OFF+1], e[CL_HIGH_OFF], e[CL_LOW_OFF+1], e[CL_LOW_OFF]};
      v.file_size = {e[SIZE_OFF+3], e[SIZE_OFF+2], e[SIZE_OFF+1], e[SIZE_OFF]};
    end
    return v;
  endfunction

  always @(posedge clk) begin
    entry_verdict_t want;
    if (!rst_n) begin
      tgt_low = '0;
      tgt_high = '0;
      tgt_len = '0;
      awaited_verdicts.delete();
      fail_count = 0;
      match_count = 0;
      end_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_TARGET_LOW:    tgt_low = cfg_data;
          CFG_TARGET_HIGH:   tgt_high = cfg_data[31:0];
          CFG_TARGET_LENGTH: tgt_len = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        awaited_verdicts.push_back(classify_entry(entry_t'(in_tdata)));
      if (out_tvalid && out_tready) begin
        if (awaited_verdicts.size() == 0) begin
          $error("result beat with no entry awaiting one: status %0d", out_tuser);
          fail_count++;
        end else begin
          want = awaited_verdicts.pop_front();
          if (out_tuser != want.status) begin
            $error("entry_status: expected %0d, got %0d", want.status, out_tuser);
            fail_count++;
          end
          if (out_tdata[31:0] != want.first_cluster) begin
            $error("first_cluster: expected %h, got %h", want.first_cluster, out_tdata[31:0]);
            fail_count++;
          end
          if (out_tdata[63:32] != want.file_size) begin
            $error("file_size: expected %h, got %h", want.file_size, out_tdata[63:32]);
            fail_count++;
          end
          if (want.status == STAT_MATCH)
            match_count++;
          if (want.status == STAT_END)
            end_count++;
        end
      end
    end
    pending_results = awaited_verdicts.size();
  end

endmodule

@@ tb/fat_short_name_entry_matcher_core_tb.sv @@
// Testbench top for the FAT short-name entry matcher: clock, reset, entry stimulus,
// result back-pressure, target programming and the verdict. Depends on fsnm_pkg,
// fsnm_match_checker and the matcher RTL.
module fat_short_name_entry_matcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fsnm_pkg::*;

  localparam int         STALL_LIMIT   = 4000;
  localparam int         HOLD_CYCLES   = 120;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         PHASES        = 7;
  localparam int         PHASE_ITEMS   = 90;
  localparam logic [1:0] CFG_UNUSED    = 2'd3;
  localparam logic [7:0] ATTR_PLAIN    = 8'h00;
  localparam logic [7:0] ATTR_ALL_FILE = 8'h27;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = CFG_TARGET_LOW;
  logic [63:0]  cfg_data = '0;

  int fail_count;
  int pending_results;
  int match_count;
  int end_count;

  int  stall_cycles = 0;
  int  entries_sent = 0;
  int  target_settings = 1;
  bit  gaps_on = 1'b1;
  bit  hold_req = 1'b0;

  logic [7:0][7:0] cur_base;
  logic [7:0][7:0] cur_ext;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fat_short_name_entry_matcher_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fsnm_match_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .match_count     (match_count),
    .end_count       (end_count)
  );

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      return 0;
    if (pick < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random back-pressure, plus one long hold on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
        n = idle_gap();
        if (n > 0) begin
          out_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  function automatic logic [7:0][7:0] text8(input string s);
    logic [7:0][7:0] r;
    r = {8{SPACE_CHAR}};
    for (int i = 0; i < s.len() && i < 8; i++)
      r[i] = s[i];
    return r;
  endfunction

  function automatic logic [159:0] rand_tail();
    return {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  function automatic logic [255:0] dir_entry(input logic [7:0][7:0] base,
                                             input logic [7:0][7:0] ext,
                                             input logic [7:0] attr,
                                             input logic [159:0] tail);
    return {tail, attr, ext[2:0], base};
  endfunction

  task automatic send_entry(input logic [255:0] beat);
    int n;
    in_tvalid <= 1'b1;
    in_tdata <= beat;
    do @(posedge clk); while (!in_tready);
    entries_sent++;
    n = idle_gap();
    if (gaps_on && n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic end_writes();
    cfg_we <= 1'b0;
    target_settings++;
  endtask

  // program the target as the 8.3 name of base/ext; unused characters get noise
  task automatic aim_at(input logic [7:0][7:0] base, input logic [7:0][7:0] ext);
    logic [11:0][7:0] chars;
    int len;
    chars = {$urandom(), $urandom(), $urandom()};
    len = 0;
    for (int i = 0; i < 8 && base[i] != SPACE_CHAR; i++) begin
      chars[len] = base[i];
      len++;
    end
    if (ext[0] != SPACE_CHAR) begin
      chars[len] = DOT_CHAR;
      len++;
      for (int i = 0; i < 3; i++)
        if (ext[i] != SPACE_CHAR) begin
          chars[len] = ext[i];
          len++;
        end
    end
    cur_base = base;
    cur_ext = ext;
    write_reg(CFG_TARGET_LOW, chars[7:0]);
    write_reg(CFG_TARGET_HIGH, {$urandom(), 32'(chars[11:8])});
    write_reg(CFG_TARGET_LENGTH, {$urandom(), 28'($urandom()), 4'(len)});
  endtask

  task automatic aim_random(input int blen, input int xlen);
    logic [7:0][7:0] base;
    logic [7:0][7:0] ext;
    base = {8{SPACE_CHAR}};
    ext = {8{SPACE_CHAR}};
    for (int i = 0; i < blen; i++)
      base[i] = (i == 0) ? 8'($urandom_range(8'h21, 8'h7E)) : 8'($urandom_range(8'h21, 8'hFF));
    for (int i = 0; i < xlen; i++)
      ext[i] = 8'($urandom_range(8'h21, 8'hFF));
    aim_at(base, ext);
  endtask

  function automatic logic [7:0] mutate_char(input logic [7:0] orig);
    case ($urandom_range(0, 3))
      0: return 8'($urandom());
      1: return SPACE_CHAR;
      2: return NUL_CHAR;
      default: return orig + 8'd1;
    endcase
  endfunction

  // mostly names built from the current target, with near misses, rejects and noise
  function automatic logic [255:0] next_entry();
    logic [7:0][7:0] b;
    logic [7:0][7:0] x;
    logic [7:0] attr;
    int pick;
    int pos;
    b = cur_base;
    x = cur_ext;
    attr = 8'($urandom()) & ~(ATTR_VOLUME | ATTR_DIR);
    pick = $urandom_range(0, 99);
    pos = $urandom_range(0, 10);
    if (pick >= 87)
      return {$urandom(), $urandom(), $urandom(), $urandom(),
              $urandom(), $urandom(), $urandom(), $urandom()};
    if (pick >= 77) begin
      pos = $urandom_range(1, 10);
      if (pos < 8) b[pos] = NUL_CHAR;
      else x[pos-8] = NUL_CHAR;
    end else if (pick >= 72) begin
      b[0] = NUL_CHAR;
    end else if (pick >= 62) begin
      case ($urandom_range(0, 3))
        0: b[0] = DELETED_MARK;
        1: attr = attr | ATTR_LFN;
        2: attr = attr | ATTR_VOLUME;
        default: attr = attr | ATTR_DIR;
      endcase
    end else if (pick >= 45) begin
      if (pos < 8) b[pos] = mutate_char(b[pos]);
      else x[pos-8] = mutate_char(x[pos-8]);
    end
    return dir_entry(b, x, attr, rand_tail());
  endfunction

  initial begin
    logic [7:0][7:0] b;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty target straight out of reset
    send_entry(dir_entry(text8(""), text8(""), ATTR_PLAIN, rand_tail()));
    send_entry(dir_entry(text8(""), text8(""), ATTR_ALL_FILE, '1));
    send_entry({{248{1'b1}}, NUL_CHAR});
    send_entry('0);
    send_entry('1);
    send_entry(dir_entry(text8("A"), text8(""), ATTR_PLAIN, rand_tail()));

    drain();
    aim_at(text8("README"), text8("TXT"));
    end_writes();
    send_entry(dir_entry(text8("README"), text8("TXT"), ATTR_ALL_FILE, rand_tail()));
    b = text8("README");
    b[0] = DELETED_MARK;
    send_entry(dir_entry(b, text8("TXT"), ATTR_PLAIN, rand_tail()));
    send_entry(dir_entry(text8("README"), text8("TXT"), ATTR_LFN, rand_tail()));
    send_entry(dir_entry(text8("README"), text8("TXT"), ATTR_VOLUME, rand_tail()));
    send_entry(dir_entry(text8("README"), text8("TXT"), ATTR_DIR, rand_tail()));
    send_entry(dir_entry(text8("README"), text8("TX"), ATTR_PLAIN, rand_tail()));

    // built name cut at a zero byte
    drain();
    aim_at(text8("AB"), text8(""));
    end_writes();
    b = text8("ABxXYZ");
    b[2] = NUL_CHAR;
    send_entry(dir_entry(b, text8("TXT"), ATTR_PLAIN, rand_tail()));
    send_entry(dir_entry(text8("AB"), text8(""), ATTR_PLAIN, rand_tail()));

    // target cut at a zero byte inside its length
    drain();
    write_reg(CFG_TARGET_LOW, 64'h0000_0044_4300_4241);
    write_reg(CFG_TARGET_LENGTH, 64'd5);
    end_writes();
    send_entry(dir_entry(text8("AB"), text8(""), ATTR_PLAIN, rand_tail()));
    send_entry(dir_entry(text8("ABC"), text8(""), ATTR_PLAIN, rand_tail()));

    drain();
    aim_at({8{8'hFF}}, text8(""));
    end_writes();
    send_entry(dir_entry({8{8'hFF}}, text8(""), ATTR_PLAIN, '1));

    // full twelve characters, then overlong lengths and an unmapped index
    drain();
    aim_at(text8("ABCDEFGH"), text8("XYZ"));
    end_writes();
    send_entry(dir_entry(text8("ABCDEFGH"), text8("XYZ"), ATTR_PLAIN, rand_tail()));
    drain();
    write_reg(CFG_TARGET_LENGTH, {60'd0, 4'hF});
    write_reg(CFG_UNUSED, '1);
    end_writes();
    send_entry(dir_entry(text8("ABCDEFGH"), text8("XYZ"), ATTR_PLAIN, rand_tail()));
    drain();
    write_reg(CFG_TARGET_HIGH, '1);
    write_reg(CFG_TARGET_LENGTH, 64'd13);
    end_writes();
    send_entry(dir_entry(text8("ABCDEFGH"), text8("XYZ"), ATTR_PLAIN, rand_tail()));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      if (p == PHASES - 1)
        aim_random(8, 3);
      else
        aim_random($urandom_range(0, 8), $urandom_range(0, 3));
      if (p == 3)
        write_reg(CFG_TARGET_LENGTH, 64'($urandom_range(13, 15)));
      end_writes();
      gaps_on = (p != 5);
      if (p == 1)
        hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_entry(next_entry());
    end

    drain();
    $display("Covered %0d entries under %0d target settings: %0d matches, %0d end markers,",
             entries_sent, target_settings, match_count, end_count);
    $display("including rejected attributes, zero-cut names and a long result-side hold.");
    if (fail_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/fsnm_pkg.sv
hw/rtl/fsnm_entry_decode.sv
hw/rtl/fsnm_target_match.sv
hw/rtl/fat_short_name_entry_matcher_core.sv
tb/fsnm_match_checker.sv
tb/fat_short_name_entry_matcher_core_tb.sv
